// File: rtl/core/ufre_pkg.sv
// Package: shared types, opcodes and helpers of the unwind frame record encoder.
`timescale 1ns / 1ps
package ufre_pkg;

	localparam logic [2:0] REQ_START  = 3'd0;
	localparam logic [2:0] REQ_SAVE   = 3'd1;
	localparam logic [2:0] REQ_SETFP  = 3'd2;
	localparam logic [2:0] REQ_ALLOC  = 3'd3;
	localparam logic [2:0] REQ_FINISH = 3'd4;

	localparam logic [7:0] OP_ADV_SHORT = 8'h40;
	localparam logic [7:0] OP_OFFSET    = 8'h80;
	localparam logic [7:0] OP_ADV1      = 8'h02;
	localparam logic [7:0] OP_ADV2      = 8'h03;
	localparam logic [7:0] OP_ADV4      = 8'h04;
	localparam logic [7:0] OP_DEF_REG   = 8'h0D;
	localparam logic [7:0] OP_DEF_OFS   = 8'h0E;
	localparam logic [7:0] OP_NOP       = 8'h00;
	localparam logic [7:0] ULEB_MASK    = 8'h7F;
	localparam logic [31:0] BASE_OFFSET = 32'd8;
	localparam logic [3:0] PC_SLOT      = 4'd8;

	// frame state handed to the byte sequencer
	typedef struct packed {
		logic [31:0] link;
		logic [31:0] code;
		logic [31:0] prol;
		logic        seen;
		logic        fp_valid;
		logic [5:0]  fp_map;
		logic [31:0] fp_off;
		logic [31:0] frame_off;
	} ufre_info_t;

	function automatic logic [5:0] map_reg(input logic [5:0] r);
		logic [5:0] m;
		case (r)
			6'd0:    m = 6'd0;
			6'd1:    m = 6'd2;
			6'd2:    m = 6'd1;
			6'd3:    m = 6'd3;
			6'd4:    m = 6'd7;
			6'd5:    m = 6'd6;
			6'd6:    m = 6'd4;
			6'd7:    m = 6'd5;
			default: m = r;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/core/ufre_if.sv
// Interfaces: request and response channels of the encoder.
`timescale 1ns / 1ps
interface ufre_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [5:0]  op_reg;
	logic [31:0] alloc_bytes;
	logic [31:0] code_bytes;
	logic [31:0] entry_record_offset;
	logic [31:0] record_offset;
	logic [31:0] prologue_length;
	logic        self_managed_stack;
	modport source(output valid, req_type, op_reg, alloc_bytes, code_bytes,
		entry_record_offset, record_offset, prologue_length, self_managed_stack,
		input ready);
	modport sink(input valid, req_type, op_reg, alloc_bytes, code_bytes,
		entry_record_offset, record_offset, prologue_length, self_managed_stack,
		output ready);
endinterface

interface ufre_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_word;
	logic        last_word;
	logic        record_built;
	logic [3:0]  pc_slot_offset;
	modport source(output valid, out_word, last_word, record_built, pc_slot_offset,
		input ready);
	modport sink(input valid, out_word, last_word, record_built, pc_slot_offset,
		output ready);
endinterface

// File: rtl/core/unwind_frame_record_encoder_top.sv
// Top level: prologue tracking, saved-register store and word assembly.
`timescale 1ns / 1ps
// Usage: items arrive on the req channel (valid/ready). Start latches the
// header and clears the prologue tracking; save, set frame pointer and
// allocate update the frame state. Each of these emits
// nothing. Finish emits the record as 64-bit little-endian words on the rsp
// channel, last_word marking the final one; a self-managed stack gives a
// single zero word with record_built low.
// On finish the byte sequencer walks the record twice, first to size it and
// then to emit it, one byte per cycle while the output register is not
// waiting, with extra steps for skipped rules and phase ends.
// req.ready is low while a record is in progress.
// A transaction on rsp is held in the output register until taken; while it
// waits the sequencer holds. A built record keeps req.ready low until its
// last word is taken; after a suppressed record a new item may be accepted
// while the zero word still waits.
// Reset clears all control state and the frame tracking; the saved-register
// store is not cleared, as only entries written since start are read.
module unwind_frame_record_encoder_top
	import ufre_pkg::*;
#(
	parameter int MAX_SAVED = 16
) (
	input logic       clk,
	input logic       arst_n,
	ufre_req_if.sink  req,
	ufre_rsp_if.source rsp
);

	localparam int CW = $clog2(MAX_SAVED + 1);
	localparam int IW = (MAX_SAVED > 1) ? $clog2(MAX_SAVED) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_SUPP = 2'd2;

	logic [1:0]    state_q;
	logic [31:0]   code_q, link_q, prol_q;
	logic          supp_q, seen_q, fpv_q;
	logic [5:0]    fpn_q;
	logic [31:0]   fpo_q, frame_q;
	logic [CW-1:0] cnt_q, sav_idx;
	logic [3:0]    num_mem [MAX_SAVED];
	logic [28:0]   fac_mem [MAX_SAVED];
	logic [3:0]    num_rd_q;
	logic [28:0]   fac_rd_q;
	logic [5:0]    save_map;
	logic          acc, stall, byte_v, byte_last, done, seq_start;
	logic [7:0]    byte_d;
	logic [2:0]    bcnt_q;
	logic [55:0]   word_q;
	logic          ov_q, olast_q, obuilt_q;
	logic [63:0]   oword_q;
	logic [32:0]   sum8, sumal;
	logic [31:0]   fo_save;
	ufre_info_t    info;

	assign acc       = req.valid && req.ready;
	assign req.ready = state_q == ST_IDLE;
	assign sum8      = {1'b0, frame_q} + 33'd8;
	assign sumal     = {1'b0, frame_q} + {1'b0, req.alloc_bytes};
	assign fo_save   = sum8[32] ? 32'hFFFF_FFFF : sum8[31:0];
	assign seq_start = acc && req.req_type == REQ_FINISH && !supp_q;
	assign stall     = ov_q && !rsp.ready;
	assign save_map  = map_reg(req.op_reg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q  <= 32'd0;
			link_q  <= 32'd0;
			prol_q  <= 32'd0;
			supp_q  <= 1'b0;
			seen_q  <= 1'b0;
			frame_q <= BASE_OFFSET;
			fpv_q   <= 1'b0;
			fpn_q   <= 6'd0;
			fpo_q   <= 32'd0;
			cnt_q   <= '0;
		end else begin
			if (acc) begin
				case (req.req_type)
					REQ_START: begin
						code_q  <= req.code_bytes;
						link_q  <= req.record_offset + 32'd4 - req.entry_record_offset;
						prol_q  <= req.prologue_length;
						supp_q  <= req.self_managed_stack;
						seen_q  <= 1'b0;
						frame_q <= BASE_OFFSET;
						fpv_q   <= 1'b0;
						fpn_q   <= 6'd0;
						fpo_q   <= 32'd0;
						cnt_q   <= '0;
					end
					REQ_SAVE: begin
						seen_q <= 1'b1;
						if (req.op_reg <= 6'd15) begin
							frame_q <= fo_save;
							if (cnt_q < CW'(MAX_SAVED)) cnt_q <= cnt_q + CW'(1);
						end
					end
					REQ_SETFP: begin
						seen_q <= 1'b1;
						fpv_q  <= 1'b1;
						fpn_q  <= req.op_reg;
						fpo_q  <= frame_q;
					end
					REQ_ALLOC: begin
						seen_q <= 1'b1;
						if (!fpv_q) frame_q <= sumal[32] ? 32'hFFFF_FFFF : sumal[31:0];
					end
					REQ_FINISH: state_q <= supp_q ? ST_SUPP : ST_RUN;
					default: ;
				endcase
			end
			if (state_q == ST_RUN && done) state_q <= ST_IDLE;
			if (state_q == ST_SUPP && !stall) state_q <= ST_IDLE;
		end
	end

	// store rules on save; read data is registered from the sequencer index
	always_ff @(posedge clk) begin
		if (acc && req.req_type == REQ_SAVE && req.op_reg <= 6'd15
				&& cnt_q < CW'(MAX_SAVED)) begin
			num_mem[cnt_q[IW-1:0]] <= save_map[3:0];
			fac_mem[cnt_q[IW-1:0]] <= fo_save[31:3];
		end
		num_rd_q <= num_mem[sav_idx[IW-1:0]];
		fac_rd_q <= fac_mem[sav_idx[IW-1:0]];
	end

	assign info = '{link: link_q, code: code_q, prol: prol_q, seen: seen_q,
		fp_valid: fpv_q, fp_map: map_reg(fpn_q), fp_off: fpo_q, frame_off: frame_q};

	ufre_seq #(.MAX_SAVED(MAX_SAVED)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (seq_start),
		.stall     (stall),
		.info      (info),
		.sav_cnt   (cnt_q),
		.sav_idx   (sav_idx),
		.sav_num   (num_rd_q),
		.sav_fac   (fac_rd_q),
		.byte_v    (byte_v),
		.byte_d    (byte_d),
		.byte_last (byte_last),
		.done      (done)
	);

	// pack bytes, lowest first; the eighth byte completes a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= 3'd0;
			ov_q   <= 1'b0;
		end else begin
			if (rsp.ready) ov_q <= 1'b0;
			if (seq_start) bcnt_q <= 3'd0;
			else if (byte_v) bcnt_q <= bcnt_q + 3'd1;
			if (byte_v && bcnt_q == 3'd7) ov_q <= 1'b1;
			if (state_q == ST_SUPP && !stall) ov_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_v) word_q <= {byte_d, word_q[55:8]};
		if (byte_v && bcnt_q == 3'd7) begin
			oword_q  <= {byte_d, word_q};
			olast_q  <= byte_last;
			obuilt_q <= 1'b1;
		end
		if (state_q == ST_SUPP && !stall) begin
			oword_q  <= 64'd0;
			olast_q  <= 1'b1;
			obuilt_q <= 1'b0;
		end
	end

	assign rsp.valid          = ov_q;
	assign rsp.out_word       = oword_q;
	assign rsp.last_word      = olast_q;
	assign rsp.record_built   = obuilt_q;
	assign rsp.pc_slot_offset = obuilt_q ? PC_SLOT : 4'd0;

	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) != ST_IDLE)
		else $error("result word appeared with no record in progress");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SAVED))
		else $error("saved-register count beyond store depth");
	a_supp_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !obuilt_q |-> olast_q)
		else $error("suppressed record word not marked last");
	a_no_byte_idle: assert property (@(posedge clk) disable iff (!arst_n)
		byte_v |-> state_q == ST_RUN)
		else $error("record byte produced outside a record");

endmodule

// File: rtl/core/ufre_seq.sv
// Byte sequencer: walks the record twice, sizing it and then emitting its bytes.
`timescale 1ns / 1ps
module ufre_seq
	import ufre_pkg::*;
#(
	parameter int MAX_SAVED = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 stall,
	input  ufre_info_t                           info,
	input  logic [$clog2(MAX_SAVED+1)-1:0]       sav_cnt,
	output logic [$clog2(MAX_SAVED+1)-1:0]       sav_idx,
	input  logic [3:0]                           sav_num,
	input  logic [28:0]                          sav_fac,
	output logic                                 byte_v,
	output logic [7:0]                           byte_d,
	output logic                                 byte_last,
	output logic                                 done
);

	localparam int CW = $clog2(MAX_SAVED + 1);

	localparam logic [3:0] P_HDR     = 4'd0;
	localparam logic [3:0] P_ADV_OP  = 4'd1;
	localparam logic [3:0] P_ADV_ARG = 4'd2;
	localparam logic [3:0] P_FP_OP   = 4'd3;
	localparam logic [3:0] P_FP_REG  = 4'd4;
	localparam logic [3:0] P_CFA_OP  = 4'd5;
	localparam logic [3:0] P_ULEB    = 4'd6;
	localparam logic [3:0] P_SAV_OP  = 4'd7;
	localparam logic [3:0] P_PAD     = 4'd8;

	logic          run_q, pass_q;
	logic [3:0]    phase_q, phase_d;
	logic [4:0]    idx_q, idx_d;
	logic [31:0]   sh_q, sh_d;
	logic [2:0]    n_q, n_d;
	logic [CW-1:0] si_q, si_d;
	logic [7:0]    pos_q, total_q;
	logic          emit, swap, fin;
	logic [7:0]    eb;
	logic [31:0]   hw, cfa_off;

	assign cfa_off = info.fp_valid ? info.fp_off : info.frame_off;

	always_comb begin
		case (idx_q[3:2])
			2'd0:    hw = {24'd0, total_q - 8'd4};
			2'd1:    hw = info.link;
			2'd2:    hw = 32'd0;
			default: hw = info.code;
		endcase
	end

	always_comb begin
		emit    = 1'b0;
		eb      = OP_NOP;
		swap    = 1'b0;
		fin     = 1'b0;
		phase_d = phase_q;
		idx_d   = idx_q;
		sh_d    = sh_q;
		n_d     = n_q;
		si_d    = si_q;
		case (phase_q)
			P_HDR: begin
				emit  = 1'b1;
				eb    = idx_q[4] ? OP_NOP : 8'(hw >> {idx_q[1:0], 3'b000});
				idx_d = idx_q + 5'd1;
				if (idx_q[4]) phase_d = P_ADV_OP;
			end
			P_ADV_OP: begin
				phase_d = P_FP_OP;
				if (info.seen && info.prol != 32'd0) begin
					emit = 1'b1;
					sh_d = info.prol;
					if (info.prol < 32'd64) begin
						eb = OP_ADV_SHORT | {2'b00, info.prol[5:0]};
					end else if (info.prol <= 32'hFF) begin
						eb = OP_ADV1; n_d = 3'd1; phase_d = P_ADV_ARG;
					end else if (info.prol <= 32'hFFFF) begin
						eb = OP_ADV2; n_d = 3'd2; phase_d = P_ADV_ARG;
					end else begin
						eb = OP_ADV4; n_d = 3'd4; phase_d = P_ADV_ARG;
					end
				end
			end
			P_ADV_ARG: begin
				emit = 1'b1;
				eb   = sh_q[7:0];
				sh_d = sh_q >> 8;
				n_d  = n_q - 3'd1;
				if (n_q == 3'd1) phase_d = P_FP_OP;
			end
			P_FP_OP: begin
				if (info.fp_valid) begin
					emit = 1'b1; eb = OP_DEF_REG; phase_d = P_FP_REG;
				end else begin
					phase_d = P_CFA_OP;
				end
			end
			P_FP_REG: begin
				emit = 1'b1; eb = {2'b00, info.fp_map}; phase_d = P_CFA_OP;
			end
			P_CFA_OP: begin
				phase_d = P_SAV_OP;
				if (cfa_off != BASE_OFFSET) begin
					emit = 1'b1; eb = OP_DEF_OFS; sh_d = cfa_off; phase_d = P_ULEB;
				end
			end
			P_ULEB: begin
				emit = 1'b1;
				eb   = {sh_q[31:7] != 25'd0, sh_q[6:0]} & (ULEB_MASK | OP_OFFSET);
				sh_d = sh_q >> 7;
				if (sh_q[31:7] == 25'd0) phase_d = P_SAV_OP;
			end
			P_SAV_OP: begin
				if (si_q < sav_cnt) begin
					emit    = 1'b1;
					eb      = OP_OFFSET | {4'd0, sav_num};
					sh_d    = {3'd0, sav_fac};
					si_d    = si_q + CW'(1);
					phase_d = P_ULEB;
				end else begin
					phase_d = P_PAD;
				end
			end
			P_PAD: begin
				if (pos_q[2:0] != 3'd0) begin
					emit = 1'b1;
				end else if (!pass_q) begin
					swap = 1'b1;
				end else begin
					fin = 1'b1;
				end
			end
			default: phase_d = P_PAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			pass_q  <= 1'b0;
			phase_q <= P_HDR;
			idx_q   <= 5'd0;
			si_q    <= '0;
			pos_q   <= 8'd0;
			total_q <= 8'd0;
		end else if (start) begin
			run_q   <= 1'b1;
			pass_q  <= 1'b0;
			phase_q <= P_HDR;
			idx_q   <= 5'd0;
			si_q    <= '0;
			pos_q   <= 8'd0;
		end else if (run_q && !stall) begin
			if (swap) begin
				// sizing pass over: rewind and emit for real
				total_q <= pos_q;
				pass_q  <= 1'b1;
				phase_q <= P_HDR;
				idx_q   <= 5'd0;
				si_q    <= '0;
				pos_q   <= 8'd0;
			end else if (fin) begin
				run_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
				si_q    <= si_d;
				if (emit) pos_q <= pos_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q && !stall) begin
			sh_q <= sh_d;
			n_q  <= n_d;
		end
	end

	assign sav_idx   = si_q;
	assign byte_v    = run_q && pass_q && emit && !stall;
	assign byte_d    = eb;
	assign byte_last = (pos_q + 8'd1) == total_q;
	assign done      = run_q && pass_q && fin && !stall;

endmodule

// File: tb/tb.sv
// Testbench: drives prologue items into the frame record encoder and checks every record word.
`timescale 1ns / 1ps
module tb;
	import ufre_pkg::*;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  reg_no;
		logic [31:0] alloc;
		logic [31:0] code;
		logic [31:0] entry_ofs;
		logic [31:0] rec_ofs;
		logic [31:0] prol;
		logic        self_stack;
	} frame_item_t;

	typedef struct packed {
		logic [63:0] word;
		logic        last;
		logic        built;
		logic [3:0]  slot;
	} record_word_t;

	logic clk;
	logic arst_n;
	ufre_req_if req ();
	ufre_rsp_if rsp ();

	unwind_frame_record_encoder_top u_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	frame_item_t  pending_items[$];
	record_word_t expected_words[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done;
	int hold_long;

	// predictor state
	logic [31:0] p_code, p_link, p_prol, p_frame, p_fp_ofs;
	logic        p_suppress, p_seen, p_fp_valid;
	logic [5:0]  p_fp_no;
	logic [3:0]  p_reg_nos[16];
	logic [28:0] p_factors[16];
	int          p_count;

	logic [7:0] rec_bytes[128];
	int         rec_len;

	function automatic logic [5:0] remap(input logic [5:0] r);
		logic [2:0] tbl[8];
		tbl = '{3'd0, 3'd2, 3'd1, 3'd3, 3'd7, 3'd6, 3'd4, 3'd5};
		return (r < 8) ? {3'b0, tbl[r[2:0]]} : r;
	endfunction

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic add_item(input frame_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic add_word(input record_word_t w);
		expected_words.insert(expected_words.size(), w);
	endtask

	task automatic emit_byte(input logic [7:0] b);
		if (rec_len < 128) begin
			rec_bytes[rec_len] = b;
			rec_len++;
		end
	endtask

	task automatic emit_word32(input logic [31:0] x);
		for (int i = 0; i < 4; i++) emit_byte(x[8*i +: 8]);
	endtask

	task automatic emit_uleb(input logic [31:0] x);
		logic [7:0] b;
		do begin
			b = {1'b0, x[6:0]};
			x = x >> 7;
			if (x != 0) b[7] = 1'b1;
			emit_byte(b);
		end while (x != 0);
	endtask

	task automatic clear_prologue();
		p_seen = 0; p_frame = BASE_OFFSET; p_fp_valid = 0; p_fp_no = 0;
		p_fp_ofs = 0; p_count = 0;
	endtask

	task automatic predict_record(input frame_item_t it);
		logic [31:0] len;
		record_word_t w;
		case (it.kind)
			REQ_START: begin
				p_code = it.code;
				p_link = it.rec_ofs + 32'd4 - it.entry_ofs;
				p_prol = it.prol;
				p_suppress = it.self_stack;
				clear_prologue();
			end
			REQ_SAVE: begin
				p_seen = 1;
				if (it.reg_no <= 15) begin
					p_frame = sat_sum(p_frame, 32'd8);
					if (p_count < 16) begin
						p_reg_nos[p_count] = 4'(remap(it.reg_no));
						p_factors[p_count] = p_frame[31:3];
						p_count++;
					end
				end
			end
			REQ_SETFP: begin
				p_seen = 1; p_fp_valid = 1; p_fp_no = it.reg_no; p_fp_ofs = p_frame;
			end
			REQ_ALLOC: begin
				p_seen = 1;
				if (!p_fp_valid) p_frame = sat_sum(p_frame, it.alloc);
			end
			REQ_FINISH: begin
				if (p_suppress) begin
					w = '{word: 64'd0, last: 1'b1, built: 1'b0, slot: 4'd0};
					add_word(w);
				end else begin
					rec_len = 0;
					emit_word32(32'd0); emit_word32(p_link); emit_word32(32'd0);
					emit_word32(p_code); emit_uleb(32'd0);
					if (p_seen && p_prol != 0) begin
						if (p_prol < 64) emit_byte(OP_ADV_SHORT | p_prol[7:0]);
						else if (p_prol <= 32'hFF) begin
							emit_byte(OP_ADV1); emit_byte(p_prol[7:0]);
						end else if (p_prol <= 32'hFFFF) begin
							emit_byte(OP_ADV2); emit_byte(p_prol[7:0]);
							emit_byte(p_prol[15:8]);
						end else begin
							emit_byte(OP_ADV4); emit_word32(p_prol);
						end
					end
					if (p_fp_valid) begin
						emit_byte(OP_DEF_REG); emit_uleb({26'd0, remap(p_fp_no)});
						if (p_fp_ofs != BASE_OFFSET) begin
							emit_byte(OP_DEF_OFS); emit_uleb(p_fp_ofs);
						end
					end else if (p_frame != BASE_OFFSET) begin
						emit_byte(OP_DEF_OFS); emit_uleb(p_frame);
					end
					for (int i = 0; i < p_count; i++) begin
						emit_byte(OP_OFFSET | {4'd0, p_reg_nos[i]});
						emit_uleb({3'd0, p_factors[i]});
					end
					while (rec_len % 8 != 0 && rec_len < 128) emit_byte(OP_NOP);
					len = 32'(rec_len - 4);
					for (int i = 0; i < 4; i++) rec_bytes[i] = len[8*i +: 8];
					for (int i = 0; i < rec_len / 8; i++) begin
						for (int b = 0; b < 8; b++) w.word[8*b +: 8] = rec_bytes[i*8 + b];
						w.last = (i + 1 == rec_len / 8);
						w.built = 1'b1;
						w.slot = PC_SLOT;
						add_word(w);
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic frame_item_t rand_item(input logic [2:0] k);
		frame_item_t it;
		it.kind = k;
		it.reg_no = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(16, 63))
			: 6'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
			0: it.alloc = $urandom;
			1: it.alloc = $urandom_range(0, 300);
			2: it.alloc = 32'hFFFF_FFF0 + $urandom_range(0, 15);
			default: it.alloc = $urandom_range(0, 70000);
		endcase
		it.code = $urandom;
		it.entry_ofs = $urandom;
		it.rec_ofs = $urandom;
		case ($urandom_range(0, 4))
			0: it.prol = 0;
			1: it.prol = $urandom_range(1, 63);
			2: it.prol = $urandom_range(64, 255);
			3: it.prol = $urandom_range(256, 65535);
			default: it.prol = $urandom;
		endcase
		it.self_stack = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	function automatic frame_item_t fixed_item(input logic [2:0] k, input logic [5:0] r,
			input logic [31:0] a, input logic [31:0] p, input logic s);
		frame_item_t it;
		it = '{kind: k, reg_no: r, alloc: a, code: 32'hFFFF_FFFF, entry_ofs: 32'h10,
			rec_ofs: 32'h0, prol: p, self_stack: s};
		return it;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		frame_item_t it;
		int n;
		arst_n = 0;
		p_code = 0; p_link = 0; p_prol = 0; p_suppress = 0;
		clear_prologue();
		// directed: header extremes, every operation, full save list, saturation
		add_item(fixed_item(REQ_FINISH, 0, 0, 0, 0));
		add_item(fixed_item(REQ_START, 0, 0, 63, 0));
		add_item(fixed_item(REQ_SAVE, 63, 0, 0, 0));
		add_item(fixed_item(REQ_FINISH, 0, 0, 0, 0));
		add_item(fixed_item(REQ_FINISH, 0, 0, 0, 0));
		add_item(fixed_item(REQ_START, 0, 0, 32'hFFFF_FFFF, 0));
		for (int i = 0; i < 17; i++)
			add_item(fixed_item(REQ_SAVE, i[5:0], 0, 0, 0));
		add_item(fixed_item(REQ_ALLOC, 0, 32'hFFFF_FFFF, 0, 0));
		add_item(fixed_item(REQ_SETFP, 6'd6, 0, 0, 0));
		add_item(fixed_item(REQ_ALLOC, 0, 32'd16, 0, 0));
		add_item(fixed_item(REQ_FINISH, 0, 0, 0, 0));
		add_item(fixed_item(3'd7, 0, 0, 0, 0));
		add_item(fixed_item(REQ_START, 0, 0, 200, 1));
		add_item(fixed_item(REQ_SAVE, 3, 0, 0, 0));
		add_item(fixed_item(REQ_FINISH, 0, 0, 0, 0));
		n = 0;
		while (n < 90) begin
			if ($urandom_range(0, 9) == 0) begin
				add_item(rand_item(3'($urandom_range(0, 7))));
				n++;
			end else begin
				add_item(rand_item(REQ_START));
				for (int i = $urandom_range(0, 12); i > 0; i--)
					add_item(rand_item(3'($urandom_range(1, 3))));
				add_item(rand_item(REQ_FINISH));
				if ($urandom_range(0, 4) == 0) add_item(rand_item(REQ_FINISH));
				n += 8;
			end
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	int gap;
	initial begin
		req.valid = 0; req.req_type = 0; req.op_reg = 0; req.alloc_bytes = 0;
		req.code_bytes = 0; req.entry_record_offset = 0; req.record_offset = 0;
		req.prologue_length = 0; req.self_managed_stack = 0;
		gap = 0; stim_done = 0;
	end

	always @(posedge clk) begin
		frame_item_t it;
		if (arst_n) begin
			// retire the accepted transaction; the head of the queue is then the next one
			if (req.valid && req.ready) begin
				it = pending_items.pop_front();
				predict_record(it);
			end
			if (!(req.valid && !req.ready)) begin
				if (gap > 0) begin
					gap <= gap - 1;
					req.valid <= 0;
				end else if (pending_items.size() > 0) begin
					it = pending_items[0];
					req.valid <= 1;
					req.req_type <= it.kind; req.op_reg <= it.reg_no;
					req.alloc_bytes <= it.alloc; req.code_bytes <= it.code;
					req.entry_record_offset <= it.entry_ofs; req.record_offset <= it.rec_ofs;
					req.prologue_length <= it.prol; req.self_managed_stack <= it.self_stack;
					gap <= ($urandom_range(0, 2) != 0) ? 0 :
						($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3));
				end else begin
					req.valid <= 0;
					stim_done <= 1;
				end
			end
		end
	end

	// monitor with random back-pressure; one long hold-off early in the run
	int stall;
	initial begin
		rsp.ready = 0; stall = 0; hold_long = 0;
	end

	always @(posedge clk) begin
		record_word_t got, want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = '{word: rsp.out_word, last: rsp.last_word, built: rsp.record_built,
					slot: rsp.pc_slot_offset};
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected word %h", got.word);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h/%b/%b/%0d actual %h/%b/%b/%0d",
								want.word, want.last, want.built, want.slot,
								got.word, got.last, got.built, got.slot);
					end
				end
			end
			if (hold_long == 0 && cycles > 200) begin
				hold_long <= 1;
				stall <= 400;
				rsp.ready <= 0;
			end else if (stall > 0) begin
				stall <= stall - 1;
				rsp.ready <= 0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
				rsp.ready <= 0;
			end else begin
				rsp.ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
